### rtl/core/foc_pkg.sv
`timescale 1ns / 1ps
package foc_pkg;

	localparam int SineEntriesDef = 512;
	localparam int GainFracDef    = 8;

	localparam int OpW   = 18;
	localparam int ProdW = 2 * OpW;
	localparam int AccW  = ProdW + 2;

	localparam int NumSteps = 34;
	localparam int StepW    = 6;

	localparam logic [63:0] Q30TwoPi  = 64'd6746518852;
	localparam logic [63:0] Q30Pi     = 64'd3373259426;
	localparam logic [63:0] Q30HalfPi = 64'd1686629713;

	// register map
	localparam logic [2:0] RegSpdKp  = 3'd0;
	localparam logic [2:0] RegSpdKi  = 3'd1;
	localparam logic [2:0] RegTrqKp  = 3'd2;
	localparam logic [2:0] RegTrqKi  = 3'd3;
	localparam logic [2:0] RegFlxKp  = 3'd4;
	localparam logic [2:0] RegFlxKi  = 3'd5;
	localparam logic [2:0] RegSpdRef = 3'd6;
	localparam logic [2:0] RegFlxRef = 3'd7;

	typedef enum logic [3:0] {
		A_DSIN, A_DCOS, A_IA, A_IB, A_BETA, A_VD, A_VQ, A_ERR, A_PREV
	} a_sel_t;

	typedef enum logic [2:0] {
		B_FRAC, B_CLK_A, B_CLK_B, B_COS, B_SIN, B_KSUM, B_KP
	} b_sel_t;

	typedef enum logic [1:0] {L_SPD, L_TRQ, L_FLX} loop_t;

	typedef enum logic [1:0] {ACC_NOP, ACC_LD, ACC_ADD, ACC_SUB} acc_op_t;

	typedef enum logic [2:0] {ROM_NONE, ROM_SA, ROM_SB, ROM_CA, ROM_CB} rom_t;

	typedef enum logic [3:0] {
		W_NONE, W_SA, W_SB, W_CA, W_CB, W_SIN, W_COS, W_BETA, W_D, W_Q,
		W_PI_SPD, W_PI_TRQ, W_PI_FLX, W_VA, W_VB
	} wr_t;

	typedef struct packed {
		rom_t    rom;
		logic    mul;
		a_sel_t  a;
		b_sel_t  b;
		loop_t   lp;
		acc_op_t acc;
		wr_t     wr;
		logic    last;
	} uop_t;

	typedef struct packed {
		logic capture;
		logic load_out;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic last;
	} ctl_status_t;

	localparam uop_t UopNop = '{rom: ROM_NONE, mul: 1'b0, a: A_IA, b: B_FRAC, lp: L_SPD,
		acc: ACC_NOP, wr: W_NONE, last: 1'b0};

	function automatic logic signed [15:0] sat16(input logic signed [AccW-1:0] v);
		if (v > AccW'(32767))
			return 16'sh7fff;
		if (v < -AccW'(32768))
			return 16'sh8000;
		return v[15:0];
	endfunction

	// micro-program: sine lookup, Clarke, Park, three PI loops, inverse Park
	function automatic uop_t uop_at(input logic [StepW-1:0] step);
		uop_t u;
		u = UopNop;
		case (step)
			6'd0: u.rom = ROM_SA;
			6'd1: begin u.rom = ROM_SB; u.wr = W_SA; end
			6'd2: begin u.rom = ROM_CA; u.wr = W_SB; end
			6'd3: begin
				u.rom = ROM_CB; u.wr = W_CA;
				u.mul = 1'b1; u.a = A_DSIN; u.b = B_FRAC;
			end
			6'd4: begin u.wr = W_CB; u.acc = ACC_LD; end
			6'd5: begin u.wr = W_SIN; u.mul = 1'b1; u.a = A_DCOS; u.b = B_FRAC; end
			6'd6: u.acc = ACC_LD;
			6'd7: begin u.wr = W_COS; u.mul = 1'b1; u.a = A_IA; u.b = B_CLK_A; end
			6'd8: begin u.acc = ACC_LD; u.mul = 1'b1; u.a = A_IB; u.b = B_CLK_B; end
			6'd9: u.acc = ACC_ADD;
			6'd10: begin u.wr = W_BETA; u.mul = 1'b1; u.a = A_IA; u.b = B_COS; end
			6'd11: begin u.acc = ACC_LD; u.mul = 1'b1; u.a = A_BETA; u.b = B_SIN; end
			6'd12: u.acc = ACC_ADD;
			6'd13: begin u.wr = W_D; u.mul = 1'b1; u.a = A_BETA; u.b = B_COS; end
			6'd14: begin u.acc = ACC_LD; u.mul = 1'b1; u.a = A_IA; u.b = B_SIN; end
			6'd15: u.acc = ACC_SUB;
			6'd16: begin
				u.wr = W_Q; u.mul = 1'b1; u.a = A_ERR; u.b = B_KSUM; u.lp = L_SPD;
			end
			6'd17: begin
				u.acc = ACC_LD; u.mul = 1'b1; u.a = A_PREV; u.b = B_KP; u.lp = L_SPD;
			end
			6'd18: u.acc = ACC_SUB;
			6'd19: u.wr = W_PI_SPD;
			6'd20: begin u.mul = 1'b1; u.a = A_ERR; u.b = B_KSUM; u.lp = L_TRQ; end
			6'd21: begin
				u.acc = ACC_LD; u.mul = 1'b1; u.a = A_PREV; u.b = B_KP; u.lp = L_TRQ;
			end
			6'd22: u.acc = ACC_SUB;
			6'd23: begin
				u.wr = W_PI_TRQ; u.mul = 1'b1; u.a = A_ERR; u.b = B_KSUM; u.lp = L_FLX;
			end
			6'd24: begin
				u.acc = ACC_LD; u.mul = 1'b1; u.a = A_PREV; u.b = B_KP; u.lp = L_FLX;
			end
			6'd25: u.acc = ACC_SUB;
			6'd26: u.wr = W_PI_FLX;
			6'd27: begin u.mul = 1'b1; u.a = A_VD; u.b = B_COS; end
			6'd28: begin u.acc = ACC_LD; u.mul = 1'b1; u.a = A_VQ; u.b = B_SIN; end
			6'd29: u.acc = ACC_SUB;
			6'd30: begin u.wr = W_VA; u.mul = 1'b1; u.a = A_VD; u.b = B_SIN; end
			6'd31: begin u.acc = ACC_LD; u.mul = 1'b1; u.a = A_VQ; u.b = B_COS; end
			6'd32: u.acc = ACC_ADD;
			6'd33: begin u.wr = W_VB; u.last = 1'b1; end
			default: u = UopNop;
		endcase
		return u;
	endfunction

endpackage

### rtl/core/field_oriented_current_control.sv
`timescale 1ns / 1ps
// Channel | Handshake                  | Payload
// cfg     | cfg_write (no wait)        | cfg_index, cfg_data
// in      | in_valid / in_ready        | current_a, current_b, rotor_angle, measured_speed
// out     | out_valid / out_ready      | voltage_alpha, voltage_beta
//
// Each sample goes through one accept, a 34-step micro-program on the single shared
// 18x18 multiplier and the sine ROM port, and a hand-off of the result to the output
// register; the next sample can be accepted only after that hand-off.
// Reset (arst_n low) clears the loop state and loads the default gains.
// A stalled output beat holds; the next sample is accepted and processed while it
// waits, and only its final hand-off waits for the output register to free up.
module field_oriented_current_control #(
	parameter int SINE_TABLE_ENTRIES = foc_pkg::SineEntriesDef,
	parameter int GAIN_FRACTION_BITS = foc_pkg::GainFracDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] current_a,
	input  logic signed [15:0] current_b,
	input  logic [15:0]        rotor_angle,
	input  logic signed [15:0] measured_speed,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] voltage_alpha,
	output logic signed [15:0] voltage_beta
);
	import foc_pkg::*;

	cmd_t        cmd;
	ctl_status_t status;

	// sequencer: accept a beat, step the micro-program, hand the result off
	foc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd),
		.status   (status)
	);

	// datapath: sine ROM, shared multiplier and accumulator, loop state, registers
	foc_datapath #(
		.SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
		.GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.current_a     (current_a),
		.current_b     (current_b),
		.rotor_angle   (rotor_angle),
		.measured_speed(measured_speed),
		.cmd           (cmd),
		.voltage_alpha (voltage_alpha),
		.voltage_beta  (voltage_beta)
	);

	// an accepted beat closes the input side until its work is done
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input accepted while busy");

	// the input side is open exactly when the sequencer is idle
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == !status.busy)
		else $error("ready disagrees with sequencer state");

	// after an accept, the micro-program runs through to its last step
	a_fixed_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##NumSteps status.last)
		else $error("micro-program length mismatch");

	// a finished sample with a stalled output keeps the output beat up
	a_hold_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(status.last && out_valid && !out_ready) |=> out_valid)
		else $error("pending output dropped");

endmodule

### rtl/core/foc_ctrl.sv
`timescale 1ns / 1ps
module foc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output foc_pkg::cmd_t        cmd,
	output foc_pkg::ctl_status_t status
);
	import foc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_RUN  = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t           state_q;
	logic [StepW-1:0] step_q;
	logic             out_valid_q;
	uop_t             uop;
	logic             load_out;

	assign uop       = uop_at(step_q);
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign cmd.capture  = in_valid && in_ready;
	assign cmd.load_out = load_out;
	assign cmd.uop      = (state_q == S_RUN) ? uop : UopNop;

	assign status.busy = (state_q != S_IDLE);
	assign status.last = (state_q == S_RUN) && uop.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					if (in_valid)
						state_q <= S_RUN;
				end
				S_RUN: begin
					if (uop.last)
						state_q <= S_DONE;
					else
						step_q <= step_q + StepW'(1);
				end
				S_DONE: begin
					if (load_out)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

### rtl/core/foc_datapath.sv
`timescale 1ns / 1ps
module foc_datapath #(
	parameter int SINE_TABLE_ENTRIES = foc_pkg::SineEntriesDef,
	parameter int GAIN_FRACTION_BITS = foc_pkg::GainFracDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	input  logic signed [15:0]  current_a,
	input  logic signed [15:0]  current_b,
	input  logic [15:0]         rotor_angle,
	input  logic signed [15:0]  measured_speed,
	input  foc_pkg::cmd_t       cmd,
	output logic signed [15:0]  voltage_alpha,
	output logic signed [15:0]  voltage_beta
);
	import foc_pkg::*;

	localparam int AddrW = $clog2(SINE_TABLE_ENTRIES);
	localparam logic [AddrW-1:0] Quarter = AddrW'(SINE_TABLE_ENTRIES / 4);
	localparam logic signed [AccW-1:0] Half = AccW'(64'd1 << (GAIN_FRACTION_BITS - 1));

	typedef logic signed [15:0] sine_tab_t [SINE_TABLE_ENTRIES];

	// quarter-accurate Q30 Taylor series, scaled to Q1.15
	function automatic sine_tab_t build_sine();
		sine_tab_t          t;
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic [63:0]        p;
		logic signed [63:0] sum;
		logic signed [63:0] val;
		logic               neg;
		int                 k;
		int                 n;
		for (k = 0; k < SINE_TABLE_ENTRIES; k++) begin
			x = (Q30TwoPi * 64'(k)) / SINE_TABLE_ENTRIES;
			neg = 1'b0;
			if (x >= Q30Pi) begin
				x = x - Q30Pi;
				neg = 1'b1;
			end
			if (x > Q30HalfPi)
				x = Q30Pi - x;
			x2 = (x * x) >> 30;
			term = x;
			sum = signed'(x);
			for (n = 1; n <= 7; n++) begin
				p = (term * x2) >> 30;
				case (n)
					1: term = p / 64'd6;
					2: term = p / 64'd20;
					3: term = p / 64'd42;
					4: term = p / 64'd72;
					5: term = p / 64'd110;
					6: term = p / 64'd156;
					default: term = p / 64'd210;
				endcase
				if (n % 2 == 1)
					sum = sum - signed'(term);
				else
					sum = sum + signed'(term);
			end
			if (sum < 0)
				sum = 0;
			val = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
			if (val > 64'sd32767)
				val = 64'sd32767;
			t[k] = neg ? 16'(-val) : 16'(val);
		end
		return t;
	endfunction

	localparam sine_tab_t SineTab = build_sine();

	// configuration
	logic [15:0]        spd_kp_q, spd_ki_q, trq_kp_q, trq_ki_q, flx_kp_q, flx_ki_q;
	logic signed [15:0] spd_ref_q, flx_ref_q;

	// sample and working registers
	logic signed [15:0] ia_q, ib_q, spd_q;
	logic [15:0]        ang_q;
	logic signed [15:0] rom_q, sa_q, sb_q, ca_q, cb_q, sin_q, cos_q;
	logic signed [15:0] beta_q, d_q, q_q, va_q, vb_q;
	logic signed [15:0] spd_out_q, trq_out_q, flx_out_q;
	logic signed [16:0] spd_prev_q, trq_prev_q, flx_prev_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  acc_q;
	logic signed [15:0] voltage_alpha_q, voltage_beta_q;

	uop_t               u;
	logic [AddrW-1:0]   idx, rom_addr;
	logic [15:0]        frac;
	logic signed [16:0] err_spd, err_trq, err_flx, err_sel, prev_sel;
	logic [15:0]        kp_sel, ki_sel;
	logic [16:0]        ksum;
	logic signed [OpW-1:0] op_a, op_b;
	logic signed [AccW-1:0] rnd15, rnd16, pi_inc, pi_sum, interp_s, interp_c;
	logic signed [15:0] mix_res, pi_res, pi_out_sel;

	assign u    = cmd.uop;
	assign idx  = ang_q[15 -: AddrW];
	assign frac = ang_q << AddrW;

	always_comb begin
		case (u.rom)
			ROM_SB:  rom_addr = idx + AddrW'(1);
			ROM_CA:  rom_addr = idx + Quarter;
			ROM_CB:  rom_addr = idx + Quarter + AddrW'(1);
			default: rom_addr = idx;
		endcase
	end

	assign err_spd = 17'(spd_ref_q) - 17'(spd_q);
	assign err_trq = 17'(spd_out_q) - 17'(q_q);
	assign err_flx = 17'(flx_ref_q) - 17'(d_q);

	always_comb begin
		case (u.lp)
			L_TRQ: begin
				err_sel = err_trq; prev_sel = trq_prev_q;
				kp_sel = trq_kp_q; ki_sel = trq_ki_q;
			end
			L_FLX: begin
				err_sel = err_flx; prev_sel = flx_prev_q;
				kp_sel = flx_kp_q; ki_sel = flx_ki_q;
			end
			default: begin
				err_sel = err_spd; prev_sel = spd_prev_q;
				kp_sel = spd_kp_q; ki_sel = spd_ki_q;
			end
		endcase
	end

	assign ksum = {1'b0, kp_sel} + {1'b0, ki_sel};

	always_comb begin
		case (u.a)
			A_DSIN:  op_a = OpW'(sb_q) - OpW'(sa_q);
			A_DCOS:  op_a = OpW'(cb_q) - OpW'(ca_q);
			A_IB:    op_a = OpW'(ib_q);
			A_BETA:  op_a = OpW'(beta_q);
			A_VD:    op_a = OpW'(flx_out_q);
			A_VQ:    op_a = OpW'(trq_out_q);
			A_ERR:   op_a = OpW'(err_sel);
			A_PREV:  op_a = OpW'(prev_sel);
			default: op_a = OpW'(ia_q);
		endcase
		case (u.b)
			B_CLK_A: op_b = OpW'(18919);
			B_CLK_B: op_b = OpW'(37837);
			B_COS:   op_b = OpW'(cos_q);
			B_SIN:   op_b = OpW'(sin_q);
			B_KSUM:  op_b = {1'b0, ksum};
			B_KP:    op_b = {2'b00, kp_sel};
			default: op_b = {2'b00, frac};
		endcase
	end

	// result shaping: rounding shifts and saturation
	assign rnd15    = (acc_q + AccW'(16384)) >>> 15;
	assign rnd16    = (acc_q + AccW'(32768)) >>> 16;
	assign mix_res  = sat16(rnd15);
	assign interp_s = AccW'(sa_q) + rnd16;
	assign interp_c = AccW'(ca_q) + rnd16;

	always_comb begin
		case (u.wr)
			W_PI_TRQ: pi_out_sel = trq_out_q;
			W_PI_FLX: pi_out_sel = flx_out_q;
			default:  pi_out_sel = spd_out_q;
		endcase
	end

	assign pi_inc = (acc_q + Half) >>> GAIN_FRACTION_BITS;
	assign pi_sum = pi_inc + AccW'(pi_out_sel);
	assign pi_res = sat16(pi_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_kp_q  <= 16'd256;
			spd_ki_q  <= 16'd0;
			trq_kp_q  <= 16'd256;
			trq_ki_q  <= 16'd0;
			flx_kp_q  <= 16'd256;
			flx_ki_q  <= 16'd0;
			spd_ref_q <= '0;
			flx_ref_q <= '0;
			spd_out_q  <= '0;
			trq_out_q  <= '0;
			flx_out_q  <= '0;
			spd_prev_q <= '0;
			trq_prev_q <= '0;
			flx_prev_q <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					RegSpdKp:  spd_kp_q  <= cfg_data;
					RegSpdKi:  spd_ki_q  <= cfg_data;
					RegTrqKp:  trq_kp_q  <= cfg_data;
					RegTrqKi:  trq_ki_q  <= cfg_data;
					RegFlxKp:  flx_kp_q  <= cfg_data;
					RegFlxKi:  flx_ki_q  <= cfg_data;
					RegSpdRef: spd_ref_q <= cfg_data;
					RegFlxRef: flx_ref_q <= cfg_data;
					default: ;
				endcase
			end
			case (u.wr)
				W_PI_SPD: begin spd_out_q <= pi_res; spd_prev_q <= err_spd; end
				W_PI_TRQ: begin trq_out_q <= pi_res; trq_prev_q <= err_trq; end
				W_PI_FLX: begin flx_out_q <= pi_res; flx_prev_q <= err_flx; end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ia_q  <= current_a;
			ib_q  <= current_b;
			ang_q <= rotor_angle;
			spd_q <= measured_speed;
		end
		if (u.rom != ROM_NONE)
			rom_q <= SineTab[rom_addr];
		if (u.mul)
			prod_q <= op_a * op_b;
		case (u.acc)
			ACC_LD:  acc_q <= AccW'(prod_q);
			ACC_ADD: acc_q <= acc_q + AccW'(prod_q);
			ACC_SUB: acc_q <= acc_q - AccW'(prod_q);
			default: ;
		endcase
		case (u.wr)
			W_SA:   sa_q   <= rom_q;
			W_SB:   sb_q   <= rom_q;
			W_CA:   ca_q   <= rom_q;
			W_CB:   cb_q   <= rom_q;
			W_SIN:  sin_q  <= interp_s[15:0];
			W_COS:  cos_q  <= interp_c[15:0];
			W_BETA: beta_q <= mix_res;
			W_D:    d_q    <= mix_res;
			W_Q:    q_q    <= mix_res;
			W_VA:   va_q   <= mix_res;
			W_VB:   vb_q   <= mix_res;
			default: ;
		endcase
		if (cmd.load_out) begin
			voltage_alpha_q <= va_q;
			voltage_beta_q  <= vb_q;
		end
	end

	assign voltage_alpha = voltage_alpha_q;
	assign voltage_beta  = voltage_beta_q;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for field_oriented_current_control.
// Each sample passes through an in-bench model of the controller: a sine table,
// Clarke and Park transforms, three cascaded incremental PI loops and inverse Park.
// That model runs when the input beat is accepted, and its result joins a queue of
// pending voltage beats. Each output beat is checked against the head of that queue.
// Configuration writes happen only while the block is idle.
module tb_top;
	import foc_pkg::*;

	typedef struct {
		logic signed [15:0] alpha;
		logic signed [15:0] beta;
	} volt_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] current_a;
	logic signed [15:0] current_b;
	logic [15:0]        rotor_angle;
	logic signed [15:0] measured_speed;
	logic               out_valid;
	logic               out_ready;
	logic signed [15:0] voltage_alpha;
	logic signed [15:0] voltage_beta;

	field_oriented_current_control dut (.*);

	// model copy of the configuration and loop state
	longint sine_lut[512];
	longint gain[6];
	longint speed_ref, flux_ref;
	longint spd_acc, spd_err_prev, trq_acc, trq_err_prev, flx_acc, flx_err_prev;

	volt_t  pending_volts[$];
	int     mismatches;
	int     send_idle_pct;
	int     recv_idle_pct;
	int     recv_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint clamp16(input longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// integer Taylor series in Q30, rounded to Q1.15
	task automatic build_sine_lut();
		longint unsigned x, x2, term;
		longint          sum, val;
		bit              neg;
		for (int k = 0; k < 512; k++) begin
			x = (Q30TwoPi * longint'(k)) / 512;
			neg = 1'b0;
			if (x >= Q30Pi) begin
				x -= Q30Pi;
				neg = 1'b1;
			end
			if (x > Q30HalfPi)
				x = Q30Pi - x;
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2)
					sum -= longint'(term);
				else
					sum += longint'(term);
			end
			if (sum < 0)
				sum = 0;
			val = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
			if (val > 32767)
				val = 32767;
			sine_lut[k] = neg ? -val : val;
		end
	endtask

	function automatic longint lut_sine(input logic [15:0] ang);
		int unsigned p, i, j;
		longint      f, a, b;
		p = int'(ang) * 512;
		i = (p >> 16) % 512;
		j = (i + 1) % 512;
		f = p & 32'hffff;
		a = sine_lut[i];
		b = sine_lut[j];
		return a + (((b - a) * f + 32768) >>> 16);
	endfunction

	function automatic longint rotate(input longint x, cx, y, cy);
		return clamp16((x * cx + y * cy + 16384) >>> 15);
	endfunction

	function automatic longint pi_update(ref longint acc, ref longint prev,
			input longint err, input longint kp, input longint ki);
		longint inc;
		inc = ((kp + ki) * err - kp * prev + 128) >>> 8;
		acc = clamp16(acc + inc);
		prev = err;
		return acc;
	endfunction

	function automatic volt_t control_step(input logic signed [15:0] ia, ib,
			input logic [15:0] ang, input logic signed [15:0] spd);
		longint s, c, beta, d, q, iq_ref, vq, vd;
		volt_t  v;
		s = lut_sine(ang);
		c = lut_sine(ang + 16'd16384);
		beta = rotate(ia, 18919, ib, 37837);
		d = rotate(ia, c, beta, s);
		q = rotate(beta, c, ia, -s);
		iq_ref = pi_update(spd_acc, spd_err_prev, speed_ref - spd, gain[0], gain[1]);
		vq = pi_update(trq_acc, trq_err_prev, iq_ref - q, gain[2], gain[3]);
		vd = pi_update(flx_acc, flx_err_prev, flux_ref - d, gain[4], gain[5]);
		v.alpha = 16'(rotate(vd, c, vq, -s));
		v.beta = 16'(rotate(vd, s, vq, c));
		return v;
	endfunction

	// drive one register beat; only called while idle
	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx < RegSpdRef)
			gain[idx] = val;
		else if (idx == RegSpdRef)
			speed_ref = longint'(signed'(val));
		else
			flux_ref = longint'(signed'(val));
	endtask

	task automatic set_gains(input logic [15:0] skp, ski, tkp, tki, fkp, fki,
			input logic [15:0] sref, fref);
		write_reg(RegSpdKp, skp);
		write_reg(RegSpdKi, ski);
		write_reg(RegTrqKp, tkp);
		write_reg(RegTrqKi, tki);
		write_reg(RegFlxKp, fkp);
		write_reg(RegFlxKi, fki);
		write_reg(RegSpdRef, sref);
		write_reg(RegFlxRef, fref);
	endtask

	// offer one sample beat, holding valid until accepted; called at a falling edge
	task automatic send_sample(input logic signed [15:0] ia, ib,
			input logic [15:0] ang, input logic signed [15:0] spd);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		current_a <= ia;
		current_b <= ib;
		rotor_angle <= ang;
		measured_speed <= spd;
		do
			@(posedge clk);
		while (!in_ready);
		pending_volts.push_back(control_step(ia, ib, ang, spd));
		@(negedge clk);
	endtask

	task automatic send_random(input int n);
		for (int k = 0; k < n; k++)
			send_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// drop valid, wait for every pending beat, then let the pipeline settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_volts.size() != 0)
			@(posedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic test_default_gains();
		send_sample(16'sh0000, 16'sh0000, 16'd0, 16'sh0000);
		send_sample(16'sh7fff, 16'sh7fff, 16'd0, 16'sh7fff);
		send_sample(-16'sh8000, -16'sh8000, 16'd16384, -16'sh8000);
		send_sample(16'sh7fff, -16'sh8000, 16'd32768, 16'sh0001);
		send_sample(-16'sh8000, 16'sh7fff, 16'd49152, 16'shffff);
		send_sample(16'sh4000, 16'shc000, 16'd65535, 16'sh7fff);
		send_sample(16'sh1234, 16'sh0567, 16'd127, -16'sh8000);
		send_sample(16'sh0001, 16'shffff, 16'd128, 16'sh0000);
		drain();
	endtask

	// extremes of gains and references, saturating the loops both ways, then moderate gains
	task automatic test_gain_extremes();
		set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
			16'h7fff, 16'h8000);
		send_sample(16'sh7fff, 16'sh7fff, 16'd8192, -16'sh8000);
		send_sample(-16'sh8000, -16'sh8000, 16'd40000, 16'sh7fff);
		send_sample(16'sh0000, 16'sh0000, 16'd0, 16'sh0000);
		send_sample(16'sh7fff, -16'sh8000, 16'd24576, 16'sh7fff);
		drain();
		set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
			16'h8000, 16'h7fff);
		send_sample(16'sh7fff, 16'sh7fff, 16'd100, 16'sh7fff);
		send_sample(-16'sh8000, 16'sh0000, 16'd60000, -16'sh8000);
		drain();
		set_gains(16'd512, 16'd16, 16'd300, 16'd40, 16'd200, 16'd8, 16'h1000, 16'hf000);
		send_sample(16'sh2000, 16'shf000, 16'd5000, 16'sh0800);
		send_sample(16'shd000, 16'sh3000, 16'd45000, -16'sh0800);
		drain();
	endtask

	// random samples under one throttle pattern with bounded gains, then a fresh random gain set
	task automatic test_random_traffic(input int send_pct, recv_pct, n);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		set_gains(16'($urandom_range(600)), 16'($urandom_range(64)),
			16'($urandom_range(600)), 16'($urandom_range(64)),
			16'($urandom_range(600)), 16'($urandom_range(64)),
			16'($urandom), 16'($urandom));
		send_random(n / 2);
		drain();
		set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		send_random(n - n / 2);
		drain();
	endtask

	// hold the output off long enough for the block to stall its input
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 400;
		send_random(12);
		drain();
	endtask

	// receiver: random stalls, or a counted hold-off when requested
	always @(negedge clk) begin
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// check each output beat against the oldest pending result
	always @(posedge clk) begin
		volt_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_volts.size() == 0) begin
				$error("unexpected output beat: alpha %0d beta %0d", voltage_alpha,
					voltage_beta);
				mismatches++;
			end else begin
				want = pending_volts.pop_front();
				if (voltage_alpha !== want.alpha) begin
					$error("voltage_alpha expected %0d actual %0d", want.alpha, voltage_alpha);
					mismatches++;
				end
				if (voltage_beta !== want.beta) begin
					$error("voltage_beta expected %0d actual %0d", want.beta, voltage_beta);
					mismatches++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		current_a = '0;
		current_b = '0;
		rotor_angle = '0;
		measured_speed = '0;
		out_ready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold = 0;
		build_sine_lut();
		gain = '{256, 0, 256, 0, 256, 0};
		speed_ref = 0;
		flux_ref = 0;
		spd_acc = 0; spd_err_prev = 0;
		trq_acc = 0; trq_err_prev = 0;
		flx_acc = 0; flx_err_prev = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_gains();
		test_gain_extremes();
		test_random_traffic(34, 51, 160);
		test_random_traffic(51, 34, 160);
		test_random_traffic(0, 0, 160);
		test_output_backpressure();

		if (pending_volts.size() != 0) begin
			$error("%0d expected beats never arrived", pending_volts.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule
